### design/rchd_pkg.sv
package rchd_pkg;

  typedef logic [1:0] func_t;
  typedef logic [1:0] cfg_idx_t;
  typedef logic signed [15:0] coord_t;

  localparam func_t FUNC_ROT  = 2'd0;
  localparam func_t FUNC_PAIR = 2'd1;
  localparam func_t FUNC_EOF  = 2'd2;

  localparam cfg_idx_t CFG_MIN_FEAT = 2'd0;
  localparam cfg_idx_t CFG_RES_THR  = 2'd1;
  localparam cfg_idx_t CFG_CONFIRM  = 2'd2;

  localparam int CFG_W   = 16;
  localparam int MUL_W   = 19;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 38;
  localparam int DVD_W   = 33;
  localparam int DEN_W   = 20;
  localparam int QUO_W   = 16;
  localparam int REM_W   = DEN_W + 1;
  localparam int SUM_W   = 32;

  localparam logic [8:0]  MIN_FEAT_RST = 9'd10;
  localparam logic [15:0] RES_THR_RST  = 16'd33;
  localparam logic [7:0]  CONFIRM_RST  = 8'd3;

  localparam logic [15:0]     RESID_MAX  = 16'h8000;
  localparam logic [SQ_W-1:0] SQRT_BIT0  = SQ_W'(1) << 36;
  localparam logic signed [PROD_W-1:0] NORM_BIAS = PROD_W'(1) << 22;
  localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(8192);
  localparam coord_t ONE_Q11 = 16'sd2048;

endpackage

### design/rotation_compensated_hover_detector.sv
// Hover detector: a frame loads three rotation rows (func 0), then matched
// feature pairs (func 1), then ends (func 2), which alone returns a
// transaction on the out_ channel. A pair runs two bearing normalizations
// (two multiplies, a 19-step square root and three 16-step divisions
// each), then three rotated dot products with their squared differences
// and a final 19-step square root, all on one multiplier and one shared
// compare/subtract unit. End of frame divides out the mean only when the
// pair count is nonzero and not below the configured minimum. in_ready is
// low until an item's work is done. A finished result waits in the output
// register while the next rows and pairs are accepted.
module rotation_compensated_hover_detector #(
  parameter int MAX_PAIRS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  rchd_pkg::cfg_idx_t              cfg_idx,
  input  logic [rchd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rchd_pkg::func_t                 in_func,
  input  logic [1:0]                      in_row,
  input  rchd_pkg::coord_t                in_rot_a,
  input  rchd_pkg::coord_t                in_rot_b,
  input  rchd_pkg::coord_t                in_rot_c,
  input  rchd_pkg::coord_t                in_prev_u,
  input  rchd_pkg::coord_t                in_prev_v,
  input  rchd_pkg::coord_t                in_curr_u,
  input  rchd_pkg::coord_t                in_curr_v,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hovering,
  output logic                            out_raw_hover,
  output logic [8:0]                      out_pairs_used,
  output logic [15:0]                     out_mean_residual
);
  import rchd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_ULD  = 3'd3;
  localparam logic [2:0] ST_UDIV = 3'd4;
  localparam logic [2:0] ST_DOT  = 3'd5;
  localparam logic [2:0] ST_MDIV = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] k_r, k_nxt;
  logic       side_r, side_nxt;
  logic       sqrt_res_r, sqrt_res_nxt;

  logic [8:0]  min_r;
  logic [15:0] thr_r;
  logic [7:0]  cfm_r;

  coord_t rot_r [3][3];
  coord_t rot_nxt [3][3];
  coord_t bp_r [3];
  coord_t bp_nxt [3];
  coord_t bc_r [3];
  coord_t bc_nxt [3];
  coord_t pu_r, pv_r, cu_r, cv_r;
  coord_t pu_nxt, pv_nxt, cu_nxt, cv_nxt;

  logic signed [PROD_W-1:0] prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [MUL_W-1:0]  d_r, d_nxt;
  logic [SQ_W-1:0]  sq_acc_r, sq_acc_nxt;
  logic [SQ_W-1:0]  x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [DEN_W-1:0] nrm_r, nrm_nxt, den_r, den_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] dvd_lo_r, dvd_lo_nxt, quo_r, quo_nxt;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] pair_cnt_r, pair_cnt_nxt;
  logic             conf_r, conf_nxt, pend_r, pend_nxt;
  logic [7:0]       run_r, run_nxt;

  logic        out_valid_r, out_valid_nxt, hov_r, hov_nxt, raw_r, raw_nxt;
  logic [8:0]  pairs_r, pairs_nxt;
  logic [15:0] mean_r, mean_nxt;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic [SQ_W-1:0] op_a, op_b;
  logic [SQ_W:0]   diff;
  logic            ge;
  logic [SQ_W-1:0] trial;
  logic [REM_W-1:0] dtrial;

  coord_t          comp_x;
  logic [15:0]     comp_mag;
  logic [DVD_W-1:0] dvd;
  logic [QUO_W-1:0] q_fin;
  coord_t          q_s;
  logic signed [PROD_W-1:0] tot, rnd_full;
  logic signed [MUL_W-1:0]  bcx, rnd19;
  logic [15:0]     resid16;
  logic [CMP_W-1:0] cnt_ext, min_ext;
  logic            too_few, no_pairs, raw_dec;
  logic [7:0]      run_upd;
  logic            accept, out_load;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // shared compare/subtract
  assign trial  = res_r + bit_r;
  assign dtrial = {rem_r[DEN_W-1:0], dvd_lo_r[QUO_W-1]};
  always_comb begin
    if (state_r == ST_SQRT) begin
      op_a = x_r;
      op_b = trial;
    end else begin
      op_a = SQ_W'(dtrial);
      op_b = SQ_W'(den_r);
    end
  end
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = !diff[SQ_W];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        if (cnt_r == 5'd0) begin
          mul_a = MUL_W'(side_r ? cu_r : pu_r);
        end else begin
          mul_a = MUL_W'(side_r ? cv_r : pv_r);
        end
        mul_b = mul_a;
      end
      ST_DOT: begin
        if (cnt_r < 5'd3) begin
          mul_a = MUL_W'(rot_r[k_r][cnt_r[1:0]]);
          mul_b = MUL_W'(bp_r[cnt_r[1:0]]);
        end else begin
          mul_a = d_r;
          mul_b = d_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (k_r)
      2'd0:    comp_x = side_r ? cu_r : pu_r;
      2'd1:    comp_x = side_r ? cv_r : pv_r;
      default: comp_x = ONE_Q11;
    endcase
  end
  assign comp_mag = comp_x[15] ? (~comp_x + 16'd1) : comp_x;
  assign dvd      = {comp_mag, 17'b0} + DVD_W'(nrm_r >> 1);
  assign q_fin    = {quo_r[QUO_W-2:0], ge};
  assign q_s      = comp_x[15] ? -$signed(q_fin) : $signed(q_fin);

  assign tot      = acc_r + prod_r;
  assign rnd_full = (tot + RND_HALF) >>> 14;
  assign rnd19    = MUL_W'(rnd_full);
  assign bcx      = MUL_W'(bc_r[k_r]);

  assign resid16 = (res_nxt > SQ_W'(RESID_MAX)) ? RESID_MAX : res_nxt[15:0];

  assign cnt_ext  = CMP_W'(pair_cnt_r);
  assign min_ext  = CMP_W'(min_r);
  assign too_few  = cnt_ext < min_ext;
  assign no_pairs = (pair_cnt_r == '0);
  assign raw_dec  = too_few ? conf_r : (no_pairs ? 1'b0 : (quo_r < thr_r));
  assign run_upd  = (raw_dec == pend_r) ? ((run_r == 8'd255) ? run_r : run_r + 8'd1)
                                        : 8'd1;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    side_nxt     = side_r;
    sqrt_res_nxt = sqrt_res_r;
    rot_nxt      = rot_r;
    bp_nxt       = bp_r;
    bc_nxt       = bc_r;
    pu_nxt       = pu_r;
    pv_nxt       = pv_r;
    cu_nxt       = cu_r;
    cv_nxt       = cv_r;
    prod_nxt     = mul_a * mul_b;
    acc_nxt      = acc_r;
    d_nxt        = d_r;
    sq_acc_nxt   = sq_acc_r;
    x_nxt        = x_r;
    res_nxt      = res_r;
    bit_nxt      = bit_r;
    nrm_nxt      = nrm_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    dvd_lo_nxt   = dvd_lo_r;
    quo_nxt      = quo_r;
    sum_nxt      = sum_r;
    pair_cnt_nxt = pair_cnt_r;
    conf_nxt     = conf_r;
    pend_nxt     = pend_r;
    run_nxt      = run_r;
    out_valid_nxt = out_valid_r && !out_ready;
    hov_nxt      = hov_r;
    raw_nxt      = raw_r;
    pairs_nxt    = pairs_r;
    mean_nxt     = mean_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_ROT: begin
              if (in_row != 2'd3) begin
                rot_nxt[in_row][0] = in_rot_a;
                rot_nxt[in_row][1] = in_rot_b;
                rot_nxt[in_row][2] = in_rot_c;
              end
            end
            FUNC_PAIR: begin
              if (pair_cnt_r < CNT_W'(MAX_PAIRS)) begin
                pu_nxt    = in_prev_u;
                pv_nxt    = in_prev_v;
                cu_nxt    = in_curr_u;
                cv_nxt    = in_curr_v;
                side_nxt  = 1'b0;
                cnt_nxt   = '0;
                state_nxt = ST_SQ;
              end
            end
            FUNC_EOF: begin
              if (!too_few && !no_pairs) begin
                rem_nxt    = REM_W'(sum_r[SUM_W-1:QUO_W]);
                dvd_lo_nxt = sum_r[QUO_W-1:0];
                den_nxt    = DEN_W'(pair_cnt_r);
                cnt_nxt    = '0;
                state_nxt  = ST_MDIV;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd1) begin
          acc_nxt = NORM_BIAS + prod_r;
        end else if (cnt_r == 5'd2) begin
          x_nxt        = SQ_W'($unsigned(acc_r + prod_r)) << 6;
          res_nxt      = '0;
          bit_nxt      = SQRT_BIT0;
          sqrt_res_nxt = 1'b0;
          state_nxt    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (ge) begin
          x_nxt   = diff[SQ_W-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == SQ_W'(1)) begin
          if (sqrt_res_r) begin
            sum_nxt      = sum_r + SUM_W'(resid16);
            pair_cnt_nxt = pair_cnt_r + CNT_W'(1);
            state_nxt    = ST_IDLE;
          end else begin
            nrm_nxt   = res_nxt[DEN_W-1:0];
            k_nxt     = '0;
            state_nxt = ST_ULD;
          end
        end
      end
      ST_ULD: begin
        rem_nxt    = REM_W'(dvd[DVD_W-1:QUO_W]);
        dvd_lo_nxt = dvd[QUO_W-1:0];
        den_nxt    = nrm_r;
        cnt_nxt    = '0;
        state_nxt  = ST_UDIV;
      end
      ST_UDIV, ST_MDIV: begin
        rem_nxt    = ge ? diff[REM_W-1:0] : dtrial;
        dvd_lo_nxt = dvd_lo_r << 1;
        quo_nxt    = q_fin;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == 5'(QUO_W - 1)) begin
          if (state_r == ST_MDIV) begin
            state_nxt = ST_FIN;
          end else begin
            if (side_r) begin
              bc_nxt[k_r] = q_s;
            end else begin
              bp_nxt[k_r] = q_s;
            end
            if (k_r != 2'd2) begin
              k_nxt     = k_r + 2'd1;
              state_nxt = ST_ULD;
            end else if (!side_r) begin
              side_nxt  = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_SQ;
            end else begin
              k_nxt      = '0;
              cnt_nxt    = '0;
              sq_acc_nxt = '0;
              state_nxt  = ST_DOT;
            end
          end
        end
      end
      ST_DOT: begin
        cnt_nxt = cnt_r + 5'd1;
        case (cnt_r)
          5'd1: acc_nxt = prod_r;
          5'd2: acc_nxt = acc_r + prod_r;
          5'd3: d_nxt = bcx - rnd19;
          5'd5: begin
            sq_acc_nxt = sq_acc_r + SQ_W'($unsigned(prod_r));
            cnt_nxt    = '0;
            if (k_r == 2'd2) begin
              x_nxt        = sq_acc_r + SQ_W'($unsigned(prod_r));
              res_nxt      = '0;
              bit_nxt      = SQRT_BIT0;
              sqrt_res_nxt = 1'b1;
              state_nxt    = ST_SQRT;
            end else begin
              k_nxt = k_r + 2'd1;
            end
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        if (out_load) begin
          if (raw_dec != pend_r) begin
            pend_nxt = raw_dec;
          end
          run_nxt = run_upd;
          if (run_upd >= cfm_r) begin
            conf_nxt = raw_dec;
          end
          out_valid_nxt = 1'b1;
          hov_nxt       = (run_upd >= cfm_r) ? raw_dec : conf_r;
          raw_nxt       = raw_dec;
          pairs_nxt     = cnt_ext[8:0];
          mean_nxt      = (too_few || no_pairs) ? 16'd0 : quo_r;
          sum_nxt       = '0;
          pair_cnt_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      side_r      <= 1'b0;
      sqrt_res_r  <= 1'b0;
      min_r       <= MIN_FEAT_RST;
      thr_r       <= RES_THR_RST;
      cfm_r       <= CONFIRM_RST;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot_r[i][j] <= '0;
        end
      end
      sum_r       <= '0;
      pair_cnt_r  <= '0;
      conf_r      <= 1'b0;
      pend_r      <= 1'b0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      side_r      <= side_nxt;
      sqrt_res_r  <= sqrt_res_nxt;
      rot_r       <= rot_nxt;
      sum_r       <= sum_nxt;
      pair_cnt_r  <= pair_cnt_nxt;
      conf_r      <= conf_nxt;
      pend_r      <= pend_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MIN_FEAT: min_r <= cfg_wdata[8:0];
          CFG_RES_THR:  thr_r <= cfg_wdata[15:0];
          CFG_CONFIRM:  cfm_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bp_r     <= bp_nxt;
    bc_r     <= bc_nxt;
    pu_r     <= pu_nxt;
    pv_r     <= pv_nxt;
    cu_r     <= cu_nxt;
    cv_r     <= cv_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    d_r      <= d_nxt;
    sq_acc_r <= sq_acc_nxt;
    x_r      <= x_nxt;
    res_r    <= res_nxt;
    bit_r    <= bit_nxt;
    nrm_r    <= nrm_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    dvd_lo_r <= dvd_lo_nxt;
    quo_r    <= quo_nxt;
    hov_r    <= hov_nxt;
    raw_r    <= raw_nxt;
    pairs_r  <= pairs_nxt;
    mean_r   <= mean_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hovering      = hov_r;
  assign out_raw_hover     = raw_r;
  assign out_pairs_used    = pairs_r;
  assign out_mean_residual = mean_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pair_cnt_r <= CNT_W'(MAX_PAIRS))
    else $error("pair count past limit");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= (SUM_W'(pair_cnt_r) << 15))
    else $error("residual sum exceeds per-pair maximum");

  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (pair_cnt_r == '0 && sum_r == '0 && out_valid_r && state_r == ST_IDLE))
    else $error("frame state not cleared after result transaction");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (run_r != 8'd0))
    else $error("run length zero with result pending");

endmodule
